@@ hw/rtl/dsas_pkg.sv @@
package dsas_pkg;

    localparam int DIGITS_DEF    = 64;
    localparam int DIGIT_W       = 4;
    localparam int POS_W         = 6;
    localparam int ACTION_W      = 3;
    localparam int MAX_DIGIT     = 9;
    localparam int DEC_BASE      = 10;
    localparam int MAX_EMIT_POS  = 63;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_A  = 3'd0,
        ACT_WR_B  = 3'd1,
        ACT_CLEAR = 3'd2,
        ACT_ADD   = 3'd3,
        ACT_SUB   = 3'd4,
        ACT_CMP   = 3'd5,
        ACT_NEG   = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_WR,
        ST_CMP,
        ST_ARITH,
        ST_EM_RD,
        ST_EM_LD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } t_cmp;

    typedef enum logic {
        KIND_DIGIT = 1'b0,
        KIND_CMP   = 1'b1
    } t_kind;

endpackage

@@ hw/rtl/dsas_digit_mem.sv @@
module dsas_digit_mem #(
    parameter int DEPTH = dsas_pkg::DIGITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [dsas_pkg::DIGIT_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [dsas_pkg::DIGIT_W-1:0] o_rdata
);

    logic [dsas_pkg::DIGIT_W-1:0] r_mem [DEPTH];
    logic [dsas_pkg::DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dsas_digit_alu.sv @@
module dsas_digit_alu (
    input  logic                         i_add,
    input  logic                         i_swap,
    input  logic                         i_cin,
    input  logic [dsas_pkg::DIGIT_W-1:0] i_a,
    input  logic [dsas_pkg::DIGIT_W-1:0] i_b,
    output logic [dsas_pkg::DIGIT_W-1:0] o_res,
    output logic                         o_cout,
    output logic                         o_lt,
    output logic                         o_gt
);

    logic [dsas_pkg::DIGIT_W:0] sum;
    logic [dsas_pkg::DIGIT_W:0] big;
    logic [dsas_pkg::DIGIT_W:0] sub;
    logic [dsas_pkg::DIGIT_W:0] base;

    assign base = (dsas_pkg::DIGIT_W + 1)'(dsas_pkg::DEC_BASE);

    always_comb begin
        sum = {1'b0, i_a} + {1'b0, i_b} + {{dsas_pkg::DIGIT_W{1'b0}}, i_cin};
        big = i_swap ? {1'b0, i_b} : {1'b0, i_a};
        sub = (i_swap ? {1'b0, i_a} : {1'b0, i_b}) + {{dsas_pkg::DIGIT_W{1'b0}}, i_cin};
        if (i_add) begin
            o_cout = (sum >= base);
            o_res  = o_cout ? dsas_pkg::DIGIT_W'(sum - base) : dsas_pkg::DIGIT_W'(sum);
        end else begin
            o_cout = (big < sub);
            o_res  = o_cout ? dsas_pkg::DIGIT_W'(big + base - sub)
                            : dsas_pkg::DIGIT_W'(big - sub);
        end
    end

    assign o_lt = (i_a < i_b);
    assign o_gt = (i_a > i_b);

endmodule

@@ hw/rtl/decimal_signed_add_sub_compare_unit.sv @@
// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_action i_digit_pos i_digit_value i_sign_neg
// output   out        o_valid / i_stall  o_kind o_out_digit o_out_pos o_out_negative
//                                        o_is_last o_overflow o_cmp_less o_cmp_equal
// One item at a time. Digit write: read, then write back.
// Clear: one zero written to both digit memories per cycle.
// Compare: one digit pair per cycle from a shared read address, then one item.
// Add/subtract: a digit pass, preceded by a magnitude compare pass when the magnitudes
// subtract, then a read state and, per emitted digit, a load state and an output state.
// Reset clears both memories; a stalled result item keeps o_stall high.
module decimal_signed_add_sub_compare_unit #(
    parameter int DIGITS = dsas_pkg::DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dsas_pkg::ACTION_W-1:0] i_action,
    input  logic [dsas_pkg::POS_W-1:0]    i_digit_pos,
    input  logic [dsas_pkg::DIGIT_W-1:0]  i_digit_value,
    input  logic                          i_sign_neg,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [dsas_pkg::DIGIT_W-1:0]  o_out_digit,
    output logic [dsas_pkg::POS_W-1:0]    o_out_pos,
    output logic                          o_out_negative,
    output logic                          o_is_last,
    output logic                          o_overflow,
    output logic                          o_cmp_less,
    output logic                          o_cmp_equal
);

    localparam int AW = $clog2(DIGITS);
    localparam int CW = $clog2(DIGITS + 1);
    localparam logic [AW-1:0] LAST = AW'(DIGITS - 1);

    dsas_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_idx_d, n_idx_d;
    logic          r_iss, n_iss;
    logic          r_dv, n_dv;
    logic          r_carry, n_carry;
    dsas_pkg::t_cmp r_cmp, n_cmp;
    logic          r_swap, n_swap;
    logic          r_add, n_add;
    logic          r_is_cmp, n_is_cmp;
    logic          r_bneg, n_bneg;
    logic [CW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_top, n_top;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_ep, n_ep;
    logic          r_a_sign, n_a_sign;
    logic          r_b_sign, n_b_sign;
    logic [CW-1:0] r_a_cnt, n_a_cnt;
    logic [CW-1:0] r_b_cnt, n_b_cnt;
    logic          r_wsel, n_wsel;
    logic [AW-1:0] r_wpos, n_wpos;
    logic [dsas_pkg::DIGIT_W-1:0] r_wval, n_wval;
    logic          r_wneg, n_wneg;

    logic                         r_o_valid, n_o_valid;
    logic                         r_o_kind, n_o_kind;
    logic [dsas_pkg::DIGIT_W-1:0] r_o_digit, n_o_digit;
    logic [dsas_pkg::POS_W-1:0]   r_o_pos, n_o_pos;
    logic                         r_o_neg, n_o_neg;
    logic                         r_o_last, n_o_last;
    logic                         r_o_ovf, n_o_ovf;
    logic                         r_o_less, n_o_less;
    logic                         r_o_equal, n_o_equal;

    logic                         a_we, b_we;
    logic [AW-1:0]                waddr, raddr;
    logic [dsas_pkg::DIGIT_W-1:0] wdata;
    logic [dsas_pkg::DIGIT_W-1:0] a_q, b_q;
    logic [dsas_pkg::DIGIT_W-1:0] alu_res;
    logic                         alu_cout, alu_lt, alu_gt;

    logic                         accept;
    logic                         pos_ok;
    logic                         pass_end;
    logic [dsas_pkg::DIGIT_W-1:0] val_clamp;
    dsas_pkg::t_action            act;
    dsas_pkg::t_cmp               cmp_now;
    logic                         nz;
    logic [CW-1:0]                acc_next;
    logic [AW-1:0]                top_fin;
    logic [dsas_pkg::DIGIT_W-1:0] old_digit;
    logic [CW-1:0]                old_cnt, new_cnt;
    logic                         res_sign;

    dsas_digit_mem #(.DEPTH(DIGITS), .AW(AW)) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (a_q)
    );

    dsas_digit_mem #(.DEPTH(DIGITS), .AW(AW)) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (b_q)
    );

    dsas_digit_alu u_alu (
        .i_add  (r_add),
        .i_swap (r_swap),
        .i_cin  (r_carry),
        .i_a    (a_q),
        .i_b    (b_q),
        .o_res  (alu_res),
        .o_cout (alu_cout),
        .o_lt   (alu_lt),
        .o_gt   (alu_gt)
    );

    assign o_stall   = (r_state != dsas_pkg::ST_IDLE);
    assign accept    = i_valid && !o_stall;
    assign act       = dsas_pkg::t_action'(i_action);
    assign pos_ok    = (32'(i_digit_pos) < DIGITS);
    assign val_clamp = (i_digit_value > dsas_pkg::DIGIT_W'(dsas_pkg::MAX_DIGIT))
                     ? dsas_pkg::DIGIT_W'(dsas_pkg::MAX_DIGIT) : i_digit_value;
    assign pass_end  = r_dv && (r_idx_d == LAST);
    assign cmp_now   = alu_gt ? dsas_pkg::CMP_GT : (alu_lt ? dsas_pkg::CMP_LT : r_cmp);
    assign nz        = (alu_res != '0);
    assign acc_next  = r_acc + CW'(nz);
    assign top_fin   = nz ? r_idx_d : r_top;
    assign old_digit = r_wsel ? b_q : a_q;
    assign old_cnt   = r_wsel ? r_b_cnt : r_a_cnt;
    assign new_cnt   = old_cnt - CW'(old_digit != '0) + CW'(r_wval != '0);
    assign res_sign  = r_add ? r_a_sign : (r_swap ? r_bneg : r_a_sign);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsas_pkg::ST_CLR: begin
                if (r_idx == LAST) begin
                    n_state = dsas_pkg::ST_IDLE;
                end
            end
            dsas_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (act)
                        dsas_pkg::ACT_WR_A,
                        dsas_pkg::ACT_WR_B: begin
                            if (pos_ok) begin
                                n_state = dsas_pkg::ST_WR;
                            end
                        end
                        dsas_pkg::ACT_CLEAR: n_state = dsas_pkg::ST_CLR;
                        dsas_pkg::ACT_ADD: begin
                            n_state = (r_a_sign == r_b_sign) ? dsas_pkg::ST_ARITH
                                                             : dsas_pkg::ST_CMP;
                        end
                        dsas_pkg::ACT_SUB: begin
                            n_state = (r_a_sign != r_b_sign) ? dsas_pkg::ST_ARITH
                                                             : dsas_pkg::ST_CMP;
                        end
                        dsas_pkg::ACT_CMP: n_state = dsas_pkg::ST_CMP;
                        default:           n_state = dsas_pkg::ST_IDLE;
                    endcase
                end
            end
            dsas_pkg::ST_WR: n_state = dsas_pkg::ST_IDLE;
            dsas_pkg::ST_CMP: begin
                if (pass_end) begin
                    n_state = r_is_cmp ? dsas_pkg::ST_OUT : dsas_pkg::ST_ARITH;
                end
            end
            dsas_pkg::ST_ARITH: begin
                if (pass_end) begin
                    n_state = dsas_pkg::ST_EM_RD;
                end
            end
            dsas_pkg::ST_EM_RD: n_state = dsas_pkg::ST_EM_LD;
            dsas_pkg::ST_EM_LD: n_state = dsas_pkg::ST_OUT;
            dsas_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = r_o_last ? dsas_pkg::ST_IDLE : dsas_pkg::ST_EM_LD;
                end
            end
            default: n_state = dsas_pkg::ST_CLR;
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_idx_d   = r_idx_d;
        n_iss     = r_iss;
        n_dv      = r_dv;
        n_carry   = r_carry;
        n_cmp     = r_cmp;
        n_swap    = r_swap;
        n_add     = r_add;
        n_is_cmp  = r_is_cmp;
        n_bneg    = r_bneg;
        n_acc     = r_acc;
        n_top     = r_top;
        n_ovf     = r_ovf;
        n_ep      = r_ep;
        n_a_sign  = r_a_sign;
        n_b_sign  = r_b_sign;
        n_a_cnt   = r_a_cnt;
        n_b_cnt   = r_b_cnt;
        n_wsel    = r_wsel;
        n_wpos    = r_wpos;
        n_wval    = r_wval;
        n_wneg    = r_wneg;
        n_o_valid = r_o_valid;
        n_o_kind  = r_o_kind;
        n_o_digit = r_o_digit;
        n_o_pos   = r_o_pos;
        n_o_neg   = r_o_neg;
        n_o_last  = r_o_last;
        n_o_ovf   = r_o_ovf;
        n_o_less  = r_o_less;
        n_o_equal = r_o_equal;
        a_we      = 1'b0;
        b_we      = 1'b0;
        waddr     = r_idx_d;
        wdata     = alu_res;
        raddr     = r_idx;

        if (r_state == dsas_pkg::ST_CMP || r_state == dsas_pkg::ST_ARITH) begin
            n_dv    = r_iss;
            n_idx_d = r_idx;
            if (r_iss) begin
                n_idx = r_idx + AW'(1);
                if (r_idx == LAST) begin
                    n_iss = 1'b0;
                end
            end
        end

        unique case (r_state)
            dsas_pkg::ST_CLR: begin
                a_we  = 1'b1;
                b_we  = 1'b1;
                waddr = r_idx;
                wdata = '0;
                n_idx = r_idx + AW'(1);
            end
            dsas_pkg::ST_IDLE: begin
                raddr = AW'(i_digit_pos);
                if (accept) begin
                    n_idx   = '0;
                    n_iss   = 1'b1;
                    n_dv    = 1'b0;
                    n_carry = 1'b0;
                    n_cmp   = dsas_pkg::CMP_EQ;
                    n_swap  = 1'b0;
                    n_acc   = '0;
                    n_top   = '0;
                    unique case (act)
                        dsas_pkg::ACT_WR_A,
                        dsas_pkg::ACT_WR_B: begin
                            n_wsel = (act == dsas_pkg::ACT_WR_B);
                            n_wpos = AW'(i_digit_pos);
                            n_wval = val_clamp;
                            n_wneg = i_sign_neg;
                        end
                        dsas_pkg::ACT_CLEAR: begin
                            n_a_sign = 1'b0;
                            n_b_sign = 1'b0;
                            n_a_cnt  = '0;
                            n_b_cnt  = '0;
                        end
                        dsas_pkg::ACT_ADD,
                        dsas_pkg::ACT_SUB: begin
                            n_bneg   = r_b_sign ^ (act == dsas_pkg::ACT_SUB);
                            n_add    = (r_a_sign == (r_b_sign ^ (act == dsas_pkg::ACT_SUB)));
                            n_is_cmp = 1'b0;
                        end
                        dsas_pkg::ACT_CMP: begin
                            n_is_cmp = 1'b1;
                        end
                        dsas_pkg::ACT_NEG: begin
                            if (r_a_cnt != '0) begin
                                n_a_sign = ~r_a_sign;
                            end
                        end
                        default: begin
                            n_iss = 1'b0;
                        end
                    endcase
                end
            end
            dsas_pkg::ST_WR: begin
                a_we  = !r_wsel;
                b_we  = r_wsel;
                waddr = r_wpos;
                wdata = r_wval;
                if (r_wsel) begin
                    n_b_cnt  = new_cnt;
                    n_b_sign = (new_cnt != '0) && r_wneg;
                end else begin
                    n_a_cnt  = new_cnt;
                    n_a_sign = (new_cnt != '0) && r_wneg;
                end
            end
            dsas_pkg::ST_CMP: begin
                if (r_dv) begin
                    n_cmp = cmp_now;
                end
                if (pass_end) begin
                    if (r_is_cmp) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = dsas_pkg::KIND_CMP;
                        n_o_digit = '0;
                        n_o_pos   = '0;
                        n_o_neg   = 1'b0;
                        n_o_last  = 1'b1;
                        n_o_ovf   = 1'b0;
                        n_o_equal = (cmp_now == dsas_pkg::CMP_EQ) && (r_a_sign == r_b_sign);
                        if (r_a_sign != r_b_sign) begin
                            n_o_less = r_a_sign;
                        end else if (r_a_sign) begin
                            n_o_less = (cmp_now == dsas_pkg::CMP_GT);
                        end else begin
                            n_o_less = (cmp_now == dsas_pkg::CMP_LT);
                        end
                    end else begin
                        n_swap  = (cmp_now == dsas_pkg::CMP_LT);
                        n_idx   = '0;
                        n_iss   = 1'b1;
                        n_dv    = 1'b0;
                        n_carry = 1'b0;
                        n_acc   = '0;
                        n_top   = '0;
                    end
                end
            end
            dsas_pkg::ST_ARITH: begin
                if (r_dv) begin
                    a_we    = 1'b1;
                    n_carry = alu_cout;
                    n_acc   = acc_next;
                    n_top   = top_fin;
                end
                if (pass_end) begin
                    n_a_cnt  = acc_next;
                    n_a_sign = (acc_next != '0) && res_sign;
                    n_ovf    = r_add && alu_cout;
                    n_ep     = (32'(top_fin) > dsas_pkg::MAX_EMIT_POS)
                             ? AW'(dsas_pkg::MAX_EMIT_POS) : top_fin;
                end
            end
            dsas_pkg::ST_EM_RD: begin
                raddr = r_ep;
            end
            dsas_pkg::ST_EM_LD: begin
                n_o_valid = 1'b1;
                n_o_kind  = dsas_pkg::KIND_DIGIT;
                n_o_digit = a_q;
                n_o_pos   = dsas_pkg::POS_W'(r_ep);
                n_o_neg   = r_a_sign;
                n_o_last  = (r_ep == '0);
                n_o_ovf   = r_ovf;
                n_o_less  = 1'b0;
                n_o_equal = 1'b0;
            end
            dsas_pkg::ST_OUT: begin
                raddr = r_ep - AW'(1);
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (!r_o_last) begin
                        n_ep = r_ep - AW'(1);
                    end
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dsas_pkg::ST_CLR;
            r_idx     <= '0;
            r_iss     <= 1'b0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
            r_a_sign  <= 1'b0;
            r_b_sign  <= 1'b0;
            r_a_cnt   <= '0;
            r_b_cnt   <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_iss     <= n_iss;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
            r_a_sign  <= n_a_sign;
            r_b_sign  <= n_b_sign;
            r_a_cnt   <= n_a_cnt;
            r_b_cnt   <= n_b_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_d   <= n_idx_d;
        r_carry   <= n_carry;
        r_cmp     <= n_cmp;
        r_swap    <= n_swap;
        r_add     <= n_add;
        r_is_cmp  <= n_is_cmp;
        r_bneg    <= n_bneg;
        r_acc     <= n_acc;
        r_top     <= n_top;
        r_ovf     <= n_ovf;
        r_ep      <= n_ep;
        r_wsel    <= n_wsel;
        r_wpos    <= n_wpos;
        r_wval    <= n_wval;
        r_wneg    <= n_wneg;
        r_o_kind  <= n_o_kind;
        r_o_digit <= n_o_digit;
        r_o_pos   <= n_o_pos;
        r_o_neg   <= n_o_neg;
        r_o_last  <= n_o_last;
        r_o_ovf   <= n_o_ovf;
        r_o_less  <= n_o_less;
        r_o_equal <= n_o_equal;
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_out_digit    = r_o_digit;
    assign o_out_pos      = r_o_pos;
    assign o_out_negative = r_o_neg;
    assign o_is_last      = r_o_last;
    assign o_overflow     = r_o_ovf;
    assign o_cmp_less     = r_o_less;
    assign o_cmp_equal    = r_o_equal;

endmodule

@@ hw/rtl/dsas_checker.sv @@
module dsas_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_kind,
    input logic [dsas_pkg::DIGIT_W-1:0]  o_out_digit,
    input logic [dsas_pkg::POS_W-1:0]    o_out_pos,
    input logic                          o_out_negative,
    input logic                          o_is_last,
    input logic                          o_overflow,
    input logic                          o_cmp_less,
    input logic                          o_cmp_equal
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_out_digit)
            && $stable(o_out_pos) && $stable(o_out_negative) && $stable(o_is_last)
            && $stable(o_overflow) && $stable(o_cmp_less) && $stable(o_cmp_equal))
        else $error("result item changed under stall");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result item waits");

    a_cmp_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_is_last && !o_overflow && !o_out_negative
            && (o_out_digit == '0) && (o_out_pos == '0) && !(o_cmp_less && o_cmp_equal))
        else $error("malformed compare item");

    a_digit_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> (o_is_last == (o_out_pos == '0))
            && (o_out_digit <= dsas_pkg::DIGIT_W'(dsas_pkg::MAX_DIGIT))
            && !o_cmp_less && !o_cmp_equal)
        else $error("malformed digit item");

endmodule

bind decimal_signed_add_sub_compare_unit dsas_checker u_dsas_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_out_digit    (o_out_digit),
    .o_out_pos      (o_out_pos),
    .o_out_negative (o_out_negative),
    .o_is_last      (o_is_last),
    .o_overflow     (o_overflow),
    .o_cmp_less     (o_cmp_less),
    .o_cmp_equal    (o_cmp_equal)
);
